/* rtl/core/pixelwise_image_combine_defines.svh */
// Assertion macros for the pixelwise image combiner.
// Included by the RTL file that carries concurrent assertions; expects clk_i and rst_ni in scope.
`ifndef PIXELWISE_IMAGE_COMBINE_DEFINES_SVH
`define PIXELWISE_IMAGE_COMBINE_DEFINES_SVH

// expression holds at every clock edge outside reset
`define PIC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define PIC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/pic_pkg.sv */
// Shared types, codes and constants of the pixelwise image combiner.
// No dependencies; used by the top level and the pipelined divider.
`timescale 1ns / 1ps
`default_nettype none
package pic_pkg;

  localparam int ACC_W      = 48;
  localparam int PIX_W      = 15;
  localparam int IDX_W      = 16;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int DIV_BPS    = 4;

  localparam logic [PIX_W-1:0] VAL_MAX = 15'h7fff;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [PIX_W-1:0]        pix_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_XOR   = 4'd2,
    OP_AVG   = 4'd3,
    OP_MIN   = 4'd4,
    OP_MAX   = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_DIV   = 4'd8,
    OP_MUL   = 4'd9,
    OP_MULNZ = 4'd10,
    OP_DIVNZ = 4'd11
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPERATION = 3'd0,
    REG_WIN_EN    = 3'd1,
    REG_WIN_LO    = 3'd2,
    REG_WIN_HI    = 3'd3,
    REG_IMG_CNT   = 3'd4,
    REG_BIN_LVL   = 3'd5,
    REG_REV       = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } res_kind_e;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  function automatic acc_t sat_acc(input logic signed [ACC_W:0] v);
    acc_t r;
    if (v[ACC_W] != v[ACC_W-1]) begin
      r = v[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = v[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/pic_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the per-pixel accumulator entries.
`timescale 1ns / 1ps
`default_nettype none
module pic_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/core/pic_div.sv */
// Pipelined unsigned restoring divider, DIV_BPS quotient bits per stage.
// Depends on pic_pkg for the bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module pic_div #(
  parameter int NW = 48,
  parameter int DW = 15
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [NW-1:0] quotient_o
);

  localparam int BPS = pic_pkg::DIV_BPS;
  localparam int LAT = (NW + BPS - 1) / BPS;
  localparam int NP  = LAT * BPS;

  logic [DW-1:0] rem_q [LAT];
  logic [DW-1:0] rem_d [LAT];
  logic [DW-1:0] den_q [LAT];
  logic [DW-1:0] den_d [LAT];
  logic [NP-1:0] num_q [LAT];
  logic [NP-1:0] num_d [LAT];

  always_comb begin
    logic [DW-1:0] r;
    logic [DW-1:0] d;
    logic [NP-1:0] n;
    logic [DW:0]   t;
    for (int s = 0; s < LAT; s++) begin
      if (s == 0) begin
        r = '0;
        n = NP'(dividend_i);
        d = divisor_i;
      end else begin
        r = rem_q[s-1];
        n = num_q[s-1];
        d = den_q[s-1];
      end
      for (int b = 0; b < BPS; b++) begin
        t = {r, n[NP-1]};
        if (t >= {1'b0, d}) begin
          r = DW'(t - {1'b0, d});
          n = {n[NP-2:0], 1'b1};
        end else begin
          r = t[DW-1:0];
          n = {n[NP-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      num_d[s] = n;
      den_d[s] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < LAT; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= num_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quotient_o = num_q[LAT-1][NW-1:0];

endmodule
`default_nettype wire

/* rtl/core/pixelwise_image_combine.sv */
// Pixelwise image combiner: one pixel word per cycle in, one finished pixel out per last-image
// pixel. The input word passes a window stage and an index-to-entry stage, then reads its
// 48-bit accumulator entry from a one-read, one-write RAM, combines (with a 12-stage divider
// for the divide operations), writes the entry back and, on the last image, goes through a
// rounding divider of 7 stages, binarise and reverse. Throughput is one word per cycle unless
// the output stalls or the word's entry is still being updated by one of 15 words ahead of it;
// such a word waits at the read stage until that write lands. Entries are undefined until a
// first-image word loads them. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i
// and the user must do so while idle; the block itself does not enforce it.
// Depends on pic_pkg, pic_ram, pic_div and pixelwise_image_combine_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pixelwise_image_combine_defines.svh"
module pixelwise_image_combine #(
  parameter int PIXELS        = 65536,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // pixel_index, pixel_value, pad
  input  logic                             s_axis_tuser,  // first_image
  input  logic                             s_axis_tlast,  // last_image
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [31:0]                      m_axis_tdata,  // out_index, out_value, pad
  input  logic                             cfg_we_i,
  input  logic [pic_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pic_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int ACC_W  = pic_pkg::ACC_W;
  localparam int FIN_NW = pic_pkg::CNT_W + pic_pkg::PIX_W;
  localparam int CLAT   = (ACC_W + pic_pkg::DIV_BPS - 1) / pic_pkg::DIV_BPS;
  localparam int FLAT   = (FIN_NW + pic_pkg::DIV_BPS - 1) / pic_pkg::DIV_BPS;
  localparam logic [32:0] RECIP = (PIXELS >= 65536) ? 33'd0 :
      33'((64'd4294967296 + 64'(PIXELS) - 64'd1) / 64'(PIXELS));
  localparam pic_pkg::acc_t ONE_FIX = pic_pkg::acc_t'(1) << FRACTION_BITS;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic          first;
    pic_pkg::idx_t idx;
    pic_pkg::pix_t pv;
    pic_pkg::idx_t q;
  } s1_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic          first;
    logic [AW-1:0] addr;
    pic_pkg::idx_t idx;
    pic_pkg::pix_t pv;
  } front_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [AW-1:0]      addr;
    pic_pkg::idx_t      idx;
    pic_pkg::res_kind_e kind;
    logic               neg;
    pic_pkg::acc_t      alt;
  } csb_t;

  typedef struct packed {
    logic          valid;
    logic          last;
    logic [AW-1:0] addr;
    pic_pkg::idx_t idx;
    pic_pkg::acc_t res;
  } sw_t;

  typedef struct packed {
    logic          valid;
    pic_pkg::idx_t idx;
    logic          pos;
    logic [47:0]   x;
    pic_pkg::cnt_t n;
  } f1_t;

  typedef struct packed {
    logic          valid;
    pic_pkg::idx_t idx;
    logic          pos;
    logic          big;
  } fsb_t;

  // configuration
  pic_pkg::op_e  op_q;
  logic          win_en_q;
  pic_pkg::pix_t win_lo_q;
  pic_pkg::pix_t win_hi_q;
  pic_pkg::cnt_t img_cnt_q;
  pic_pkg::pix_t bin_lvl_q;
  logic          rev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= pic_pkg::OP_AND;
      win_en_q  <= 1'b0;
      win_lo_q  <= '0;
      win_hi_q  <= pic_pkg::VAL_MAX;
      img_cnt_q <= pic_pkg::cnt_t'(2);
      bin_lvl_q <= '0;
      rev_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pic_pkg::cfg_reg_e'(cfg_idx_i))
        pic_pkg::REG_OPERATION: op_q      <= pic_pkg::op_e'(cfg_data_i[3:0]);
        pic_pkg::REG_WIN_EN:    win_en_q  <= cfg_data_i[0];
        pic_pkg::REG_WIN_LO:    win_lo_q  <= cfg_data_i;
        pic_pkg::REG_WIN_HI:    win_hi_q  <= cfg_data_i;
        pic_pkg::REG_IMG_CNT:   img_cnt_q <= cfg_data_i[pic_pkg::CNT_W-1:0];
        pic_pkg::REG_BIN_LVL:   bin_lvl_q <= cfg_data_i;
        pic_pkg::REG_REV:       rev_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline registers
  s1_t           s1_q, s1_d;
  front_t        s2_q, s2_d;
  front_t        s3_q, s3_d;
  csb_t          sb_q [CLAT+1];
  csb_t          sb0_d, sb_mid;
  pic_pkg::acc_t s4_a_q, s4_a_d;
  logic [47:0]   s4_abs_q, s4_abs_d;
  pic_pkg::pix_t s4_p_q;
  logic signed [63:0] prod_q, prod_d;
  sw_t           sw_q, sw_d;
  f1_t           f1_q, f1_d;
  fsb_t          fsb_q [FLAT+1];
  fsb_t          fsb0_d;
  logic [FIN_NW-1:0] fin_y_q, fin_y_d;
  pic_pkg::cnt_t fin_n_q;
  logic          o_valid_q;
  pic_pkg::idx_t out_idx_q;
  pic_pkg::pix_t out_val_q, out_val_d;

  logic          adv_b, issue, hazard, s1_free, s2_free;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [ACC_W-1:0] ram_rdata;
  logic [ACC_W-1:0] cdiv_q;
  logic [FIN_NW-1:0] fdiv_q;

  assign adv_b   = !o_valid_q || m_axis_tready;
  assign issue   = s2_q.valid && !hazard && adv_b;
  assign s2_free = !s2_q.valid || issue;
  assign s1_free = !s1_q.valid || s2_free;
  assign s_axis_tready = s1_free;

  // window and entry quotient
  always_comb begin
    logic [48:0]   rp;
    pic_pkg::pix_t pv;
    logic          keep;
    pv   = s_axis_tdata[30:16];
    keep = !win_en_q || (pv >= win_lo_q && pv <= win_hi_q);
    rp   = 49'(s_axis_tdata[15:0]) * 49'(RECIP);
    s1_d.valid = s_axis_tvalid;
    s1_d.last  = s_axis_tlast;
    s1_d.first = s_axis_tuser;
    s1_d.idx   = s_axis_tdata[15:0];
    s1_d.pv    = keep ? pv : '0;
    s1_d.q     = rp[47:32];
  end

  always_comb begin
    logic [40:0] r_full;
    r_full = 41'(s1_q.idx) - 41'(s1_q.q) * 41'(PIXELS);
    s2_d.valid = s1_q.valid;
    s2_d.last  = s1_q.last;
    s2_d.first = s1_q.first;
    s2_d.addr  = r_full[AW-1:0];
    s2_d.idx   = s1_q.idx;
    s2_d.pv    = s1_q.pv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      if (s1_free) s1_q <= s1_d;
      if (s2_free) s2_q <= s2_d;
    end
  end

  // hold the read while an older word still owns the entry
  always_comb begin
    hazard = s3_q.valid && (s3_q.addr == s2_q.addr);
    for (int k = 0; k <= CLAT; k++) begin
      hazard = hazard || (sb_q[k].valid && (sb_q[k].addr == s2_q.addr));
    end
    hazard = hazard || (sw_q.valid && (sw_q.addr == s2_q.addr));
  end

  assign ram_re    = issue;
  assign ram_raddr = s2_q.addr;
  assign ram_we    = sw_q.valid && adv_b;
  assign ram_waddr = sw_q.addr;

  pic_ram #(
    .WIDTH (ACC_W),
    .DEPTH (PIXELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (sw_q.res),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s3_d       = s2_q;
    s3_d.valid = issue;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
    end else if (adv_b) begin
      s3_q <= s3_d;
    end
  end

  // combine
  always_comb begin
    pic_pkg::acc_t a, pf;
    logic signed [ACC_W:0] sum, dif;
    logic a_pos, a_zero, p_pos;
    pf     = pic_pkg::acc_t'(s3_q.pv) << FRACTION_BITS;
    a      = s3_q.first ? pf : pic_pkg::acc_t'(ram_rdata);
    a_pos  = !a[ACC_W-1] && (a != '0);
    a_zero = (a == '0);
    p_pos  = (s3_q.pv != '0);
    sum    = {a[ACC_W-1], a} + {pf[ACC_W-1], pf};
    dif    = {a[ACC_W-1], a} - {pf[ACC_W-1], pf};
    sb0_d.valid = s3_q.valid;
    sb0_d.last  = s3_q.last;
    sb0_d.addr  = s3_q.addr;
    sb0_d.idx   = s3_q.idx;
    sb0_d.neg   = a[ACC_W-1];
    sb0_d.kind  = pic_pkg::KIND_SIMPLE;
    sb0_d.alt   = a;
    unique case (op_q)
      pic_pkg::OP_AND: sb0_d.alt = (a_pos && p_pos) ? ONE_FIX : '0;
      pic_pkg::OP_OR:  sb0_d.alt = (a_pos || p_pos) ? ONE_FIX : '0;
      pic_pkg::OP_XOR:
        sb0_d.alt = ((a_pos && !p_pos) || (a_zero && p_pos)) ? ONE_FIX : '0;
      pic_pkg::OP_AVG, pic_pkg::OP_ADD: sb0_d.alt = pic_pkg::sat_acc(sum);
      pic_pkg::OP_SUB: sb0_d.alt = pic_pkg::sat_acc(dif);
      pic_pkg::OP_MIN: sb0_d.alt = (a < pf) ? a : pf;
      pic_pkg::OP_MAX: sb0_d.alt = (a > pf) ? a : pf;
      pic_pkg::OP_DIV: begin
        if (!p_pos) sb0_d.alt = '0;
        else sb0_d.kind = pic_pkg::KIND_DIV;
      end
      pic_pkg::OP_MUL: sb0_d.kind = pic_pkg::KIND_MUL;
      pic_pkg::OP_MULNZ: begin
        if (a_zero) sb0_d.alt = pf;
        else if (p_pos) sb0_d.kind = pic_pkg::KIND_MUL;
      end
      pic_pkg::OP_DIVNZ: begin
        if (a_zero) sb0_d.alt = pf;
        else if (p_pos) sb0_d.kind = pic_pkg::KIND_DIV;
      end
      default: ;
    endcase
    if (s3_q.first) begin
      sb0_d.kind = pic_pkg::KIND_SIMPLE;
      sb0_d.alt  = pf;
    end
    s4_a_d   = a;
    s4_abs_d = a[ACC_W-1] ? 48'(-a) : 48'(a);
  end

  assign prod_d = $signed(s4_a_q) * $signed({1'b0, s4_p_q});

  always_comb begin
    sb_mid = sb_q[1];
    if (sb_q[1].kind == pic_pkg::KIND_MUL) begin
      if ((&prod_q[63:ACC_W-1]) || !(|prod_q[63:ACC_W-1])) begin
        sb_mid.alt = prod_q[ACC_W-1:0];
      end else begin
        sb_mid.alt = prod_q[63] ? pic_pkg::ACC_MIN : pic_pkg::ACC_MAX;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= CLAT; k++) sb_q[k] <= '0;
    end else if (adv_b) begin
      sb_q[0] <= sb0_d;
      for (int k = 1; k <= CLAT; k++) begin
        sb_q[k] <= (k == 2) ? sb_mid : sb_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      s4_a_q   <= s4_a_d;
      s4_abs_q <= s4_abs_d;
      s4_p_q   <= s3_q.pv;
      prod_q   <= prod_d;
    end
  end

  pic_div #(
    .NW (ACC_W),
    .DW (pic_pkg::PIX_W)
  ) u_comb_div (
    .clk_i      (clk_i),
    .en_i       (adv_b),
    .dividend_i (s4_abs_q),
    .divisor_i  (s4_p_q),
    .quotient_o (cdiv_q)
  );

  // write-back stage
  always_comb begin
    sw_d.valid = sb_q[CLAT].valid;
    sw_d.last  = sb_q[CLAT].last;
    sw_d.addr  = sb_q[CLAT].addr;
    sw_d.idx   = sb_q[CLAT].idx;
    if (sb_q[CLAT].kind == pic_pkg::KIND_DIV) begin
      sw_d.res = sb_q[CLAT].neg ? pic_pkg::acc_t'(-cdiv_q) : pic_pkg::acc_t'(cdiv_q);
    end else begin
      sw_d.res = sb_q[CLAT].alt;
    end
  end

  // finish: round, clamp, divide by image count for OP_AVG, then binarise and reverse
  always_comb begin
    pic_pkg::cnt_t n;
    n = (op_q == pic_pkg::OP_AVG && img_cnt_q != '0) ? img_cnt_q : pic_pkg::cnt_t'(1);
    f1_d.valid = sw_q.valid && sw_q.last;
    f1_d.idx   = sw_q.idx;
    f1_d.pos   = !sw_q.res[ACC_W-1] && (sw_q.res != '0);
    f1_d.x     = 48'(sw_q.res[ACC_W-2:0]) + (48'(n) << (FRACTION_BITS - 1));
    f1_d.n     = n;
  end

  always_comb begin
    logic [47:0] y;
    y = f1_q.x >> FRACTION_BITS;
    fsb0_d.valid = f1_q.valid;
    fsb0_d.idx   = f1_q.idx;
    fsb0_d.pos   = f1_q.pos;
    fsb0_d.big   = y >= (48'(f1_q.n) << pic_pkg::PIX_W);
    fin_y_d      = y[FIN_NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= '0;
      f1_q <= '0;
      for (int k = 0; k <= FLAT; k++) fsb_q[k] <= '0;
    end else if (adv_b) begin
      sw_q     <= sw_d;
      f1_q     <= f1_d;
      fsb_q[0] <= fsb0_d;
      for (int k = 1; k <= FLAT; k++) fsb_q[k] <= fsb_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b) begin
      fin_y_q <= fin_y_d;
      fin_n_q <= f1_q.n;
    end
  end

  pic_div #(
    .NW (FIN_NW),
    .DW (pic_pkg::CNT_W)
  ) u_fin_div (
    .clk_i      (clk_i),
    .en_i       (adv_b),
    .dividend_i (fin_y_q),
    .divisor_i  (fin_n_q),
    .quotient_o (fdiv_q)
  );

  always_comb begin
    pic_pkg::pix_t v;
    if (!fsb_q[FLAT].pos) v = '0;
    else if (fsb_q[FLAT].big) v = pic_pkg::VAL_MAX;
    else v = fdiv_q[pic_pkg::PIX_W-1:0];
    if (bin_lvl_q != '0) v = (v > bin_lvl_q) ? pic_pkg::pix_t'(1) : '0;
    if (rev_q) v = (v == '0) ? pic_pkg::pix_t'(1) : '0;
    out_val_d = v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (adv_b) begin
      o_valid_q <= fsb_q[FLAT].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_b && fsb_q[FLAT].valid) begin
      out_idx_q <= fsb_q[FLAT].idx;
      out_val_q <= out_val_d;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {1'b0, out_val_q, out_idx_q};

  `PIC_ASSERT_ALWAYS(a_no_rw_collision,
      !(ram_re && ram_we && ram_raddr == ram_waddr),
      "read and write of one entry in one cycle")
  `PIC_ASSERT_NEXT(a_issue_lands, issue, s3_q.valid, "issued word missing at read stage")
  `PIC_ASSERT_NEXT(a_wb_holds, sw_q.valid && !adv_b,
      sw_q.valid && $stable(sw_q.addr), "write-back word lost in stall")
  `PIC_ASSERT_ALWAYS(a_binary_out,
      !(m_axis_tvalid && (bin_lvl_q != '0 || rev_q)) || out_val_q <= 15'd1,
      "binary output out of range")

endmodule
`default_nettype wire

/* sim/pixelwise_image_combine_tb.sv */
// Testbench for pixelwise_image_combine: streams image passes, predicts each finished pixel
// and checks the output stream word by word. Depends on pic_pkg and the combiner RTL.
`timescale 1ns / 1ps
module pixelwise_image_combine_tb;

  localparam longint ONE_FIX = 64'sd65536;
  localparam longint SAT_HI  = (64'sd1 <<< 47) - 1;
  localparam longint SAT_LO  = -(64'sd1 <<< 47);
  localparam int     SETTLE  = 40;

  typedef struct packed {
    logic [15:0] index;
    logic [14:0] value;
  } pixel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;  // pixel_index, pixel_value, pad
  logic        s_axis_tuser = 1'b0;  // first_image
  logic        s_axis_tlast = 1'b0;  // last_image
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;  // out_index, out_value, pad
  logic        cfg_we_i = 1'b0;
  logic [pic_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [pic_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  pixelwise_image_combine DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  logic [3:0]  op_r;
  logic        win_en_r, rev_r;
  logic [14:0] win_lo_r, win_hi_r, bin_r;
  logic [10:0] img_cnt_r;

  longint     acc_mem [65536];
  bit         loaded  [65536];
  pixel_out_t finished_q [$];
  int         fail_cnt = 0;
  int         sent_cnt = 0;
  bit         quiet = 1'b0;

  function automatic longint sat48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint fold_pixel(longint a, longint p);
    longint pf;
    pf = p * ONE_FIX;
    case (op_r)
      pic_pkg::OP_AND:   return (a > 0 && p > 0) ? ONE_FIX : 0;
      pic_pkg::OP_OR:    return (a > 0 || p > 0) ? ONE_FIX : 0;
      pic_pkg::OP_XOR:   return ((a > 0 && p == 0) || (a == 0 && p > 0)) ? ONE_FIX : 0;
      pic_pkg::OP_AVG, pic_pkg::OP_ADD: return sat48(a + pf);
      pic_pkg::OP_MIN:   return a < pf ? a : pf;
      pic_pkg::OP_MAX:   return a > pf ? a : pf;
      pic_pkg::OP_SUB:   return sat48(a - pf);
      pic_pkg::OP_DIV:   return p == 0 ? 0 : a / p;
      pic_pkg::OP_MUL:   return sat48(a * p);
      pic_pkg::OP_MULNZ: return a == 0 ? pf : (p != 0 ? sat48(a * p) : a);
      pic_pkg::OP_DIVNZ: return a == 0 ? pf : (p != 0 ? a / p : a);
      default:           return a;
    endcase
  endfunction

  function automatic logic [14:0] round_pixel(longint a);
    longint n, den, q;
    logic [14:0] v;
    n = 1;
    if (op_r == pic_pkg::OP_AVG && img_cnt_r != 0) n = longint'(img_cnt_r);
    if (a <= 0) begin
      v = '0;
    end else begin
      den = n * ONE_FIX;
      q = (a + den / 2) / den;
      v = q > 32767 ? 15'h7fff : q[14:0];
    end
    if (bin_r > 0) v = (v > bin_r) ? 15'd1 : 15'd0;
    if (rev_r) v = (v == 0) ? 15'd1 : 15'd0;
    return v;
  endfunction

  task automatic predict_pixel(logic [15:0] idx, logic [14:0] val, bit first, bit last);
    longint a;
    pixel_out_t r;
    if (win_en_r && (val < win_lo_r || val > win_hi_r)) val = '0;
    if (first) a = longint'(val) * ONE_FIX;
    else a = fold_pixel(acc_mem[idx], longint'(val));
    acc_mem[idx] = a;
    loaded[idx] = 1'b1;
    if (last) begin
      r.index = idx;
      r.value = round_pixel(a);
      finished_q.push_back(r);
    end
  endtask

  task automatic send_pixel(logic [15:0] idx, logic [14:0] val, bit first, bit last);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, idx};
    s_axis_tuser  <= first;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(idx, val, first, last);
    sent_cnt++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (finished_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(pic_pkg::cfg_reg_e r, int v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= r;
    cfg_data_i <= v[14:0];
    @(posedge clk_i);
    case (r)
      pic_pkg::REG_OPERATION: op_r      = v[3:0];
      pic_pkg::REG_WIN_EN:    win_en_r  = v[0];
      pic_pkg::REG_WIN_LO:    win_lo_r  = v[14:0];
      pic_pkg::REG_WIN_HI:    win_hi_r  = v[14:0];
      pic_pkg::REG_IMG_CNT:   img_cnt_r = v[10:0];
      pic_pkg::REG_BIN_LVL:   bin_r     = v[14:0];
      default:                rev_r     = v[0];
    endcase
  endtask

  task automatic set_config(int op, int wen, int lo, int hi, int cnt, int bin, int rev);
    drain_results();
    write_reg(pic_pkg::REG_OPERATION, op);
    write_reg(pic_pkg::REG_WIN_EN, wen);
    write_reg(pic_pkg::REG_WIN_LO, lo);
    write_reg(pic_pkg::REG_WIN_HI, hi);
    write_reg(pic_pkg::REG_IMG_CNT, cnt);
    write_reg(pic_pkg::REG_BIN_LVL, bin);
    write_reg(pic_pkg::REG_REV, rev);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [14:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return 15'd0;
      1:       return 15'h7fff;
      2:       return 15'($urandom_range(0, 15));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // Send n_img passes over n_pix pixels, in a fresh order each pass, with occasional
  // stray words on entries of the set; a stray on an unloaded entry is sent as first-image.
  task automatic run_images(int n_pix, int n_img);
    logic [15:0] pix [$];
    logic [15:0] idx;
    bit first;
    for (int i = 0; i < n_pix; i++) begin
      case ($urandom_range(0, 9))
        0:       pix.push_back(16'h0000);
        1:       pix.push_back(16'hffff);
        default: pix.push_back(16'($urandom_range(0, 65535)));
      endcase
    end
    for (int img = 0; img < n_img; img++) begin
      pix.shuffle();
      foreach (pix[i]) begin
        send_pixel(pix[i], pick_value(), img == 0, img == n_img - 1);
        if ($urandom_range(0, 19) == 0) begin
          idx = pix[$urandom_range(0, pix.size() - 1)];
          first = loaded[idx] ? 1'($urandom_range(0, 1)) : 1'b1;
          send_pixel(idx, pick_value(), first, 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    static int stall_left = 0;
    pixel_out_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.index = m_axis_tdata[15:0];
      got.value = m_axis_tdata[30:16];
      if (finished_q.size() == 0) begin
        $error("unexpected word: out_index %0d out_value %0d", got.index, got.value);
        fail_cnt++;
      end else begin
        want = finished_q.pop_front();
        if (got.index !== want.index) begin
          $error("out_index: expected %0d, actual %0d", want.index, got.index);
          fail_cnt++;
        end
        if (got.value !== want.value) begin
          $error("out_value: expected %0d, actual %0d", want.value, got.value);
          fail_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic test_reset_config();
    op_r = pic_pkg::OP_AND; win_en_r = 1'b0; win_lo_r = 15'd0; win_hi_r = 15'h7fff;
    img_cnt_r = 11'd2; bin_r = 15'd0; rev_r = 1'b0;
    send_pixel(16'h0000, 15'h7fff, 1, 0);
    send_pixel(16'hffff, 15'd0, 1, 1);
    send_pixel(16'h0000, 15'd3, 0, 1);
  endtask

  task automatic test_each_operation();
    for (int op = 0; op < 16; op++) begin
      set_config(op, 0, 0, 32767, 2, 0, 0);
      send_pixel(16'h1234, 15'h7fff, 1, 0);
      send_pixel(16'h1234, (op % 2) ? 15'd0 : 15'd7, 0, 1);
    end
  endtask

  task automatic test_window_and_finish();
    set_config(pic_pkg::OP_AVG, 1, 100, 200, 0, 0, 1);
    send_pixel(16'd5, 15'd99, 1, 0);
    send_pixel(16'd5, 15'd150, 0, 1);
    set_config(pic_pkg::OP_ADD, 1, 300, 200, 1024, 32767, 0);
    send_pixel(16'd6, 15'd250, 1, 1);
    set_config(pic_pkg::OP_MAX, 0, 32767, 0, 2047, 1, 1);
    send_pixel(16'd7, 15'd1, 1, 0);
    send_pixel(16'd7, 15'd2, 0, 1);
  endtask

  task automatic test_random();
    while (sent_cnt < 1400) begin
      set_config($urandom_range(0, 15), $urandom_range(0, 1),
                 $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32767),
                 $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 32767),
                 $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 2047),
                 $urandom_range(0, 2) == 0 ? pick_value() : 0, $urandom_range(0, 1));
      repeat ($urandom_range(1, 4)) run_images($urandom_range(1, 20), $urandom_range(1, 4));
      if (sent_cnt > 1200) quiet = 1'b1;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_each_operation();
    test_window_and_finish();
    test_random();
    drain_results();
    if (fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
